/* sv/isodt_pkg.sv */
package isodt_pkg;

  localparam int unsigned VAL_W  = 24;
  localparam int unsigned CFG_W  = 14;
  localparam int unsigned CIDX_W = 1;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_MIN_YEAR     = 1'd0;
  localparam logic [CIDX_W-1:0] CFG_CENTURY_BASE = 1'd1;

  localparam logic [CFG_W-1:0] MIN_YEAR_RST     = 14'd2020;
  localparam logic [CFG_W-1:0] CENTURY_BASE_RST = 14'd2000;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_T     = 8'h54;

  localparam logic [VAL_W-1:0] ACC_MAX    = 24'hFFFFFF;
  localparam logic [VAL_W-1:0] YEAR_SHORT = 24'd100;
  localparam logic [VAL_W-1:0] MONTH_MAX  = 24'd12;
  localparam logic [VAL_W-1:0] DAY_MAX    = 24'd31;
  localparam logic [VAL_W-1:0] HOUR_MAX   = 24'd23;
  localparam logic [VAL_W-1:0] MINSEC_MAX = 24'd59;

  typedef struct packed {
    logic [7:0] code;
    logic       end_of_string;
  } in_t;

  typedef struct packed {
    logic             ok;
    logic             date_given;
    logic             time_given;
    logic [VAL_W-1:0] year_value;
    logic [3:0]       month_value;
    logic [4:0]       day_value;
    logic [4:0]       hour_value;
    logic [5:0]       minute_value;
    logic [5:0]       second_value;
  } out_t;

  // fields collected for one string, handed from the parser to the checker
  typedef struct packed {
    logic                  past_separator;
    logic                  dash_seen;
    logic                  colon_seen;
    logic                  fault;
    logic [1:0]            field_count;
    logic [2:0][VAL_W-1:0] fields;
    logic [2:0][VAL_W-1:0] saved;
    logic                  date_valid;
  } rec_t;

  function automatic logic [VAL_W-1:0] expand_year(input logic [VAL_W-1:0] y,
                                                   input logic [CFG_W-1:0] base);
    logic [VAL_W-1:0] r;
    r = (y < YEAR_SHORT) ? (y + {{(VAL_W-CFG_W){1'b0}}, base}) : y;
    return r;
  endfunction

  function automatic logic date_in_range(input logic [2:0][VAL_W-1:0] v,
                                         input logic [CFG_W-1:0] min_year,
                                         input logic [CFG_W-1:0] base);
    logic [VAL_W-1:0] y;
    y = expand_year(v[0], base);
    return (y >= {{(VAL_W-CFG_W){1'b0}}, min_year}) &&
           (v[1] >= 24'd1) && (v[1] <= MONTH_MAX) &&
           (v[2] >= 24'd1) && (v[2] <= DAY_MAX);
  endfunction

endpackage

/* sv/isodt_parser.sv */
module isodt_parser #(
  parameter int unsigned MAX_DIGITS = 7
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  isodt_pkg::in_t               in_data,
  input  logic [isodt_pkg::CFG_W-1:0]  min_year,
  input  logic [isodt_pkg::CFG_W-1:0]  century_base,
  output logic                         rec_valid,
  output isodt_pkg::rec_t              rec_data,
  input  logic                         rec_stall
);
  import isodt_pkg::*;

  localparam int unsigned DC_W = $clog2(MAX_DIGITS + 1);

  typedef struct packed {
    logic                  ps;
    logic                  dash;
    logic                  colon;
    logic                  flt;
    logic [1:0]            cnt;
    logic [DC_W-1:0]       dc;
    logic [VAL_W-1:0]      acc;
    logic [2:0][VAL_W-1:0] fs;
  } pstate_t;

  localparam pstate_t PSTATE_CLR = '0;

  function automatic pstate_t close_field(input pstate_t s);
    pstate_t r;
    r = s;
    if (s.dc != '0) begin
      if (s.cnt != 2'd3) begin
        r.fs[s.cnt] = s.acc;
        r.cnt       = s.cnt + 2'd1;
      end else begin
        r.flt = 1'b1;
      end
    end
    r.dc  = '0;
    r.acc = '0;
    return r;
  endfunction

  // entries past the fill count read as zero
  function automatic logic [2:0][VAL_W-1:0] mask_fields(input logic [2:0][VAL_W-1:0] fs,
                                                        input logic [1:0] cnt);
    logic [2:0][VAL_W-1:0] m;
    for (int i = 0; i < 3; i++) begin
      m[i] = (2'(i) < cnt) ? fs[i] : '0;
    end
    return m;
  endfunction

  logic                  inq_valid_r, inq_valid_nxt;
  in_t                   inq_r;
  pstate_t               st_r, st_nxt;
  logic [2:0][VAL_W-1:0] saved_r, saved_nxt;
  logic                  date_valid_r, date_valid_nxt;
  logic                  rec_valid_r, rec_valid_nxt;
  rec_t                  rec_r, rec_nxt;
  logic                  step;
  logic                  accept;

  assign step     = inq_valid_r &&
                    (!inq_r.end_of_string || !rec_valid_r || !rec_stall);
  assign in_stall = inq_valid_r && !step;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    pstate_t               s;
    logic [VAL_W+3:0]      prod;
    logic [2:0][VAL_W-1:0] m;
    logic                  is_digit;
    s              = st_r;
    saved_nxt      = saved_r;
    date_valid_nxt = date_valid_r;
    rec_nxt        = rec_r;
    prod           = '0;
    m              = '0;
    is_digit       = (inq_r.code >= CH_ZERO) && (inq_r.code <= CH_NINE);
    if (step) begin
      if (is_digit) begin
        if (s.dc >= DC_W'(MAX_DIGITS)) begin
          s.flt = 1'b1;
        end else begin
          prod  = {1'b0, s.acc, 3'b000} + {3'b000, s.acc, 1'b0} +
                  {{(VAL_W){1'b0}}, inq_r.code[3:0]};
          s.acc = (prod > {4'b0000, ACC_MAX}) ? ACC_MAX : prod[VAL_W-1:0];
          s.dc  = s.dc + DC_W'(1);
        end
      end else if (!s.ps && (inq_r.code == CH_DASH || inq_r.code == CH_COLON)) begin
        s = close_field(s);
        if (inq_r.code == CH_DASH) begin
          s.dash = 1'b1;
        end else begin
          s.colon = 1'b1;
        end
      end else if (!s.ps && inq_r.code == CH_T) begin
        // close the date part and start over on the time part
        s              = close_field(s);
        m              = mask_fields(s.fs, s.cnt);
        date_valid_nxt = !s.flt && !s.colon && (s.cnt == 2'd3) &&
                         date_in_range(m, min_year, century_base);
        saved_nxt      = m;
        s.cnt          = 2'd0;
        s.flt          = 1'b0;
        s.ps           = 1'b1;
      end else if (s.ps && inq_r.code == CH_COLON) begin
        s = close_field(s);
      end else begin
        s.flt = 1'b1;
      end

      if (inq_r.end_of_string) begin
        s                      = close_field(s);
        rec_nxt.past_separator = s.ps;
        rec_nxt.dash_seen      = s.dash;
        rec_nxt.colon_seen     = s.colon;
        rec_nxt.fault          = s.flt;
        rec_nxt.field_count    = s.cnt;
        rec_nxt.fields         = mask_fields(s.fs, s.cnt);
        rec_nxt.saved          = saved_nxt;
        rec_nxt.date_valid     = date_valid_nxt;
        s                      = PSTATE_CLR;
        date_valid_nxt         = 1'b0;
      end
    end
    st_nxt = s;
  end

  always_comb begin
    if (accept) begin
      inq_valid_nxt = 1'b1;
    end else if (step) begin
      inq_valid_nxt = 1'b0;
    end else begin
      inq_valid_nxt = inq_valid_r;
    end

    if (step && inq_r.end_of_string) begin
      rec_valid_nxt = 1'b1;
    end else if (!rec_stall) begin
      rec_valid_nxt = 1'b0;
    end else begin
      rec_valid_nxt = rec_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inq_valid_r  <= 1'b0;
      st_r         <= PSTATE_CLR;
      date_valid_r <= 1'b0;
      rec_valid_r  <= 1'b0;
    end else begin
      inq_valid_r  <= inq_valid_nxt;
      st_r         <= st_nxt;
      date_valid_r <= date_valid_nxt;
      rec_valid_r  <= rec_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      inq_r <= in_data;
    end
    saved_r <= saved_nxt;
    rec_r   <= rec_nxt;
  end

  assign rec_valid = rec_valid_r;
  assign rec_data  = rec_r;

  a_dc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.dc <= DC_W'(MAX_DIGITS))
    else $error("digit count beyond limit");

  a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (step && inq_r.end_of_string) |=>
      (rec_valid_r && !st_r.ps && st_r.cnt == 2'd0 && st_r.dc == '0 && !date_valid_r))
    else $error("string end did not emit a record and clear the parse state");

  a_rec_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (rec_valid_r && rec_stall) |=> (rec_valid_r && $stable(rec_r)))
    else $error("stalled record changed");

endmodule

/* sv/isodt_checker.sv */
module isodt_validate (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        rec_valid,
  input  isodt_pkg::rec_t             rec_data,
  output logic                        rec_stall,
  input  logic [isodt_pkg::CFG_W-1:0] min_year,
  input  logic [isodt_pkg::CFG_W-1:0] century_base,
  output logic                        out_valid,
  input  logic                        out_stall,
  output isodt_pkg::out_t             out_data
);
  import isodt_pkg::*;

  logic out_valid_r, out_valid_nxt;
  out_t out_r, out_nxt;

  assign rec_stall = out_valid_r && out_stall;

  always_comb begin
    logic                  dg;
    logic                  tg;
    logic                  dok;
    logic                  tok;
    logic                  time_ok;
    logic [2:0][VAL_W-1:0] dv;
    logic [2:0][VAL_W-1:0] tv;
    time_ok = !rec_data.fault && (rec_data.field_count != 2'd0) &&
              (rec_data.fields[0] <= HOUR_MAX) &&
              (rec_data.fields[1] <= MINSEC_MAX) &&
              (rec_data.fields[2] <= MINSEC_MAX);
    dv  = '0;
    tv  = '0;
    dok = 1'b1;
    tok = 1'b1;
    priority if (rec_data.past_separator) begin
      dg  = 1'b1;
      tg  = 1'b1;
      dv  = rec_data.saved;
      dok = rec_data.date_valid;
      tv  = rec_data.fields;
      tok = time_ok;
    end else if (rec_data.dash_seen) begin
      dg  = 1'b1;
      tg  = 1'b0;
      dv  = rec_data.fields;
      dok = !rec_data.fault && !rec_data.colon_seen && (rec_data.field_count == 2'd3) &&
            date_in_range(rec_data.fields, min_year, century_base);
    end else begin
      dg  = 1'b0;
      tg  = 1'b1;
      tv  = rec_data.fields;
      tok = time_ok;
    end
    out_nxt.ok           = dok && tok;
    out_nxt.date_given   = dg;
    out_nxt.time_given   = tg;
    out_nxt.year_value   = dg ? expand_year(dv[0], century_base) : '0;
    out_nxt.month_value  = dv[1][3:0];
    out_nxt.day_value    = dv[2][4:0];
    out_nxt.hour_value   = tv[0][4:0];
    out_nxt.minute_value = tv[1][5:0];
    out_nxt.second_value = tv[2][5:0];
  end

  assign out_valid_nxt = rec_stall ? out_valid_r : rec_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_valid && !rec_stall) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_ok_given: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.ok) |-> (out_r.date_given || out_r.time_given))
    else $error("ok result with neither date nor time");

  a_ok_hour: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.ok && out_r.time_given) |->
      (out_r.hour_value <= 5'd23 && out_r.minute_value <= 6'd59 &&
       out_r.second_value <= 6'd59))
    else $error("ok result with time out of range");

endmodule

/* sv/iso_datetime_string_parser_top.sv */
// channel  dir  handshake                 payload
// in_      in   in_valid / in_stall       isodt_pkg::in_t   (code, end_of_string)
// out_     out  out_valid / out_stall     isodt_pkg::out_t  (ok ... second_value)
// cfg_     in   cfg_valid / cfg_ready     cfg_index, cfg_data (14 bit)
//
// One character is taken every cycle while in_stall is low; the request
// with end_of_string passes the input register, parse stage and check stage
// to the output. Reset is synchronous: config returns to 2020 / 2000 and the
// parse state clears. out_stall backs up through the stages to in_stall only
// while a result waits; characters that end no string keep flowing.
module iso_datetime_string_parser_top #(
  parameter int unsigned MAX_DIGITS = 7
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  isodt_pkg::in_t               in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output isodt_pkg::out_t              out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [isodt_pkg::CIDX_W-1:0] cfg_index,
  input  logic [isodt_pkg::CFG_W-1:0]  cfg_data
);
  import isodt_pkg::*;

  logic [CFG_W-1:0] min_year_r, min_year_nxt;
  logic [CFG_W-1:0] century_base_r, century_base_nxt;
  logic             rec_valid;
  logic             rec_stall;
  rec_t             rec_data;

  assign cfg_ready = 1'b1;

  always_comb begin
    min_year_nxt     = min_year_r;
    century_base_nxt = century_base_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MIN_YEAR:     min_year_nxt     = cfg_data;
        CFG_CENTURY_BASE: century_base_nxt = cfg_data;
        default:          ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_year_r     <= MIN_YEAR_RST;
      century_base_r <= CENTURY_BASE_RST;
    end else begin
      min_year_r     <= min_year_nxt;
      century_base_r <= century_base_nxt;
    end
  end

  isodt_parser #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .min_year     (min_year_r),
    .century_base (century_base_r),
    .rec_valid    (rec_valid),
    .rec_data     (rec_data),
    .rec_stall    (rec_stall)
  );

  isodt_validate u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .rec_valid    (rec_valid),
    .rec_data     (rec_data),
    .rec_stall    (rec_stall),
    .min_year     (min_year_r),
    .century_base (century_base_r),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data)
  );

endmodule

/* dv/isodt_checker.sv */
`timescale 1ns / 100ps

module isodt_checker #(
  parameter int unsigned MAX_DIGITS = 7
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  isodt_pkg::in_t               in_data,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  isodt_pkg::out_t              out_data,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [isodt_pkg::CIDX_W-1:0] cfg_index,
  input  logic [isodt_pkg::CFG_W-1:0]  cfg_data,
  output int                           fail_count,
  output int                           pending
);
  import isodt_pkg::*;

  logic [CFG_W-1:0] min_year_r;
  logic [CFG_W-1:0] base_r;

  logic             after_t;
  logic             dash_r;
  logic             colon_r;
  logic             fault_r;
  logic             date_ok_r;
  int unsigned      nfields;
  int unsigned      ndigits;
  logic [VAL_W-1:0] acc;
  logic [VAL_W-1:0] fld [3];
  logic [VAL_W-1:0] sav [3];

  out_t             parsed_q [$];
  int               errs;

  function automatic void clear_string();
    after_t   = 1'b0;
    dash_r    = 1'b0;
    colon_r   = 1'b0;
    fault_r   = 1'b0;
    date_ok_r = 1'b0;
    nfields   = 0;
    ndigits   = 0;
    acc       = '0;
    foreach (fld[i]) begin
      fld[i] = '0;
      sav[i] = '0;
    end
  endfunction

  function automatic void close_run();
    if (ndigits > 0) begin
      if (nfields < 3) begin
        fld[nfields] = acc;
        nfields++;
      end else begin
        fault_r = 1'b1;
      end
    end
    ndigits = 0;
    acc     = '0;
  endfunction

  function automatic logic [VAL_W-1:0] to_year(input logic [VAL_W-1:0] y);
    return (y < YEAR_SHORT) ? y + base_r : y;
  endfunction

  function automatic logic date_checks(input logic [VAL_W-1:0] v [3]);
    logic [VAL_W-1:0] y;
    y = to_year(v[0]);
    return (y >= min_year_r) && (v[1] >= 1) && (v[1] <= MONTH_MAX) &&
           (v[2] >= 1) && (v[2] <= DAY_MAX);
  endfunction

  function automatic logic time_checks();
    return !fault_r && (nfields >= 1) && (fld[0] <= HOUR_MAX) &&
           (fld[1] <= MINSEC_MAX) && (fld[2] <= MINSEC_MAX);
  endfunction

  function automatic void parse_char(input in_t item);
    logic [31:0]      sum;
    logic             dg;
    logic             tg;
    logic             dok;
    logic             tok;
    logic [VAL_W-1:0] dv [3];
    logic [VAL_W-1:0] tv [3];
    out_t             res;

    if (item.code >= CH_ZERO && item.code <= CH_NINE) begin
      if (ndigits >= MAX_DIGITS) begin
        fault_r = 1'b1;
      end else begin
        sum = 32'(acc) * 32'd10 + 32'(item.code - CH_ZERO);
        acc = (sum > 32'(ACC_MAX)) ? ACC_MAX : sum[VAL_W-1:0];
        ndigits++;
      end
    end else if (!after_t && (item.code == CH_DASH || item.code == CH_COLON)) begin
      close_run();
      if (item.code == CH_DASH) dash_r = 1'b1;
      else colon_r = 1'b1;
    end else if (!after_t && item.code == CH_T) begin
      // freeze the date part and start collecting the time part
      close_run();
      date_ok_r = !fault_r && !colon_r && (nfields == 3) && date_checks(fld);
      foreach (fld[i]) begin
        sav[i] = fld[i];
        fld[i] = '0;
      end
      nfields = 0;
      fault_r = 1'b0;
      after_t = 1'b1;
    end else if (after_t && item.code == CH_COLON) begin
      close_run();
    end else begin
      fault_r = 1'b1;
    end

    if (!item.end_of_string) return;

    close_run();
    foreach (dv[i]) begin
      dv[i] = '0;
      tv[i] = '0;
    end
    dok = 1'b1;
    tok = 1'b1;
    if (after_t) begin
      dg  = 1'b1;
      tg  = 1'b1;
      dv  = sav;
      dok = date_ok_r;
      tv  = fld;
      tok = time_checks();
    end else if (dash_r) begin
      dg  = 1'b1;
      tg  = 1'b0;
      dv  = fld;
      dok = !fault_r && !colon_r && (nfields == 3) && date_checks(fld);
    end else begin
      dg  = 1'b0;
      tg  = 1'b1;
      tv  = fld;
      tok = time_checks();
    end

    res.ok           = dok && tok;
    res.date_given   = dg;
    res.time_given   = tg;
    res.year_value   = dg ? to_year(dv[0]) : '0;
    res.month_value  = dv[1][3:0];
    res.day_value    = dv[2][4:0];
    res.hour_value   = tv[0][4:0];
    res.minute_value = tv[1][5:0];
    res.second_value = tv[2][5:0];
    parsed_q.push_back(res);
    clear_string();
  endfunction

  function automatic string show(input out_t r);
    return $sformatf("ok=%0b date=%0b time=%0b %0d-%0d-%0d %0d:%0d:%0d",
                     r.ok, r.date_given, r.time_given, r.year_value, r.month_value,
                     r.day_value, r.hour_value, r.minute_value, r.second_value);
  endfunction

  always @(posedge clk) begin : watch
    out_t want;
    logic bad;

    if (!rst_n) begin
      min_year_r = MIN_YEAR_RST;
      base_r     = CENTURY_BASE_RST;
      clear_string();
      parsed_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MIN_YEAR:     min_year_r = cfg_data;
          CFG_CENTURY_BASE: base_r = cfg_data;
          default: ;
        endcase
      end

      if (in_valid && !in_stall) parse_char(in_data);

      if (out_valid && !out_stall) begin
        if (parsed_q.size() == 0) begin
          if (errs < 10) $display("%0t: result with nothing pending: %s", $realtime,
                                  show(out_data));
          errs++;
        end else begin
          want = parsed_q.pop_front();
          bad = (out_data.ok !== want.ok) ||
                (out_data.date_given !== want.date_given) ||
                (out_data.time_given !== want.time_given) ||
                (out_data.year_value !== want.year_value) ||
                (out_data.month_value !== want.month_value) ||
                (out_data.day_value !== want.day_value) ||
                (out_data.hour_value !== want.hour_value) ||
                (out_data.minute_value !== want.minute_value) ||
                (out_data.second_value !== want.second_value);
          if (bad) begin
            if (errs < 10) begin
              $display("%0t: mismatch", $realtime);
              $display("  want %s", show(want));
              $display("  got  %s", show(out_data));
            end
            errs++;
          end
        end
      end
    end

    fail_count <= errs;
    pending    <= parsed_q.size();
  end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import isodt_pkg::*;

  localparam int unsigned CHAR_BUDGET = 1850;
  localparam int unsigned PHASES      = 5;
  localparam int unsigned CYCLE_LIMIT = 400000;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  in_t               in_data;
  logic              out_valid;
  logic              out_stall;
  out_t              out_data;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CIDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]  cfg_data;

  int                fail_count;
  int                pending;
  int unsigned       cycle_cnt;
  int unsigned       chars_sent;
  int unsigned       stall_left;
  int unsigned       gap_pct;
  int unsigned       stall_pct;

  logic [7:0]        str_buf [$];

  iso_datetime_string_parser_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  isodt_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver back-pressure in random bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(0, 18);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic put_char(input logic [7:0] c, input logic eos);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {c, eos};
    do @(posedge clk); while (in_stall);
    chars_sent++;
  endtask

  task automatic send_str();
    foreach (str_buf[i]) put_char(str_buf[i], i == str_buf.size() - 1);
  endtask

  // hold the sender until every result has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_W-1:0] min_year, input logic [CFG_W-1:0] base);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_MIN_YEAR;
    cfg_data  <= min_year;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_CENTURY_BASE;
    cfg_data  <= base;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic void add_text(input string txt);
    for (int i = 0; i < txt.len(); i++) str_buf.push_back(txt[i]);
  endfunction

  function automatic void add_num(input int unsigned v);
    int unsigned pad;
    pad = ($urandom_range(0, 15) == 0) ? $urandom_range(2, 8) : $urandom_range(0, 1);
    repeat (pad) str_buf.push_back(CH_ZERO);
    add_text($sformatf("%0d", v));
  endfunction

  function automatic void add_date();
    int unsigned y;
    case ($urandom_range(0, 9))
      0, 1, 2:    y = $urandom_range(0, 99);
      3, 4, 5, 6: y = $urandom_range(1900, 2100);
      7:          y = $urandom_range(0, 9999);
      8:          y = $urandom_range(10000, 9999999);
      default:    y = $urandom_range(10000000, 999999999);
    endcase
    add_num(y);
    repeat (2) begin
      case ($urandom_range(0, 19))
        0:       str_buf.push_back(CH_COLON);
        1, 2:    begin str_buf.push_back(CH_DASH); str_buf.push_back(CH_DASH); end
        default: str_buf.push_back(CH_DASH);
      endcase
      add_num(($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 12));
    end
    if ($urandom_range(0, 11) == 0) begin
      str_buf.push_back(CH_DASH);
      add_num($urandom_range(0, 99));
    end
  endfunction

  function automatic void add_time();
    if ($urandom_range(0, 14) != 0)
      add_num(($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 23));
    if ($urandom_range(0, 3) != 0) begin
      str_buf.push_back(CH_COLON);
      if ($urandom_range(0, 14) == 0) str_buf.push_back(CH_COLON);
      add_num(($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 59));
      if ($urandom_range(0, 2) != 0) begin
        str_buf.push_back(CH_COLON);
        add_num(($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 59));
      end
    end
    if ($urandom_range(0, 11) == 0) begin
      str_buf.push_back(CH_COLON);
      if ($urandom_range(0, 1) == 0) add_num($urandom_range(0, 99));
    end
  endfunction

  function automatic void add_noise();
    repeat ($urandom_range(1, 10)) begin
      case ($urandom_range(0, 7))
        0, 1, 2, 3: str_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        4:          str_buf.push_back(CH_DASH);
        5:          str_buf.push_back(CH_COLON);
        6:          str_buf.push_back(CH_T);
        default:    str_buf.push_back(8'($urandom_range(0, 255)));
      endcase
    end
  endfunction

  function automatic void build_string();
    str_buf.delete();
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5:      add_date();
      6, 7, 8, 9, 10:        add_time();
      11, 12, 13, 14, 15: begin
        add_date();
        str_buf.push_back(CH_T);
        add_time();
      end
      16: begin
        str_buf.push_back(CH_T);
        add_time();
      end
      17: begin
        add_date();
        str_buf.push_back(CH_T);
      end
      default: add_noise();
    endcase
    // corrupt one character now and then
    if ($urandom_range(0, 9) == 0)
      str_buf[$urandom_range(0, str_buf.size() - 1)] = 8'($urandom_range(0, 255));
  endfunction

  initial begin
    string directed [$];
    logic [CFG_W-1:0] min_year;
    logic [CFG_W-1:0] base;

    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    out_stall  = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = CFG_MIN_YEAR;
    cfg_data   = '0;
    gap_pct    = 0;
    stall_pct  = 0;
    stall_left = 0;
    chars_sent = 0;
    cycle_cnt  = 0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // short year, plain time, long run, extra field, colon in a date,
    // lone colon, dash after the T
    directed = '{"0-12-1", "23:59", "12345678", "1:2:3:4", "1:2-3", ":", "T-"};
    gap_pct   = 15;
    stall_pct = 15;
    foreach (directed[k]) begin
      str_buf.delete();
      add_text(directed[k]);
      send_str();
    end
    str_buf = '{8'h00};
    send_str();
    str_buf = '{8'hFF};
    send_str();

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      case (ph)
        0: begin min_year = 14'd0;    base = 14'd0;    end
        1: begin min_year = 14'd9999; base = 14'd9900; end
        3: begin min_year = 14'd1970; base = 14'd1900; end
        default: begin
          min_year = 14'($urandom_range(0, 9999));
          base     = 14'($urandom_range(0, 9900));
        end
      endcase
      write_cfg(min_year, base);
      gap_pct   = (ph == PHASES - 1) ? 0 : $urandom_range(0, 30);
      stall_pct = (ph == PHASES - 1) ? 0 : $urandom_range(0, 30);
      while (chars_sent < (ph + 1) * CHAR_BUDGET / PHASES) begin
        build_string();
        send_str();
      end
    end

    drain();
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
